/* rtl/qsd_pkg.sv */
// Shared types and character constants for the form query string decoder.
// No dependencies; compiled first.
`default_nettype none

package qsd_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 2;
  // Most results that a single input item can cause
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

  localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26; // ampersand
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D; // equals
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B; // plus
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25; // percent
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20; // space

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE     = 2'd0,
    KIND_KEY_END  = 2'd1,
    KIND_PAIR_END = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_NONE  = 2'd0, // no escape pending
    PH_PCT   = 2'd1, // percent seen
    PH_DIGIT = 2'd2  // percent and first hex digit seen
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] data;
  } result_t;

endpackage

`default_nettype wire

/* rtl/qsd_if.sv */
// Valid/ready channel interfaces for the decoder: input bytes, results, config.
// Depends on qsd_pkg.
`default_nettype none

interface qsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [qsd_pkg::CHAR_W-1:0]  char_in;
  logic                        char_valid;
  logic                        string_end;

  modport source (output valid, output char_in, output char_valid, output string_end,
                  input ready);
  modport sink   (input valid, input char_in, input char_valid, input string_end,
                  output ready);
endinterface

interface qsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [qsd_pkg::KIND_W-1:0]  item_kind;
  logic [qsd_pkg::CHAR_W-1:0]  byte_out;
  logic                        run_last;

  modport source (output valid, output item_kind, output byte_out, output run_last,
                  input ready);
  modport sink   (input valid, input item_kind, input byte_out, input run_last,
                  output ready);
endinterface

interface qsd_cfg_if;
  logic valid;
  logic ready;
  logic query_mode;

  modport source (output valid, output query_mode, input ready);
  modport sink   (input valid, input query_mode, output ready);
endinterface

`default_nettype wire

/* rtl/form_query_string_decoder_top.sv */
// Top level of the form query string decoder: decode step and result buffer.
// Depends on qsd_pkg and the channel interfaces in qsd_if.sv.
`default_nettype none

// Decodes a form-encoded query string one byte per input transfer. Each input
// transfer yields zero to four results (decoded bytes, key-end and pair-end
// marks), which leave one per cycle through the output channel while the
// receiver is ready. The whole decode step is done in the cycle of the input
// transfer and its results are loaded into a four-entry result buffer; the next
// input is taken in the same cycle that the last buffered result is transferred
// out. Throughput is thus one input per cycle for bytes giving one result, on
// the same condition; several results hold off the next input at the single
// output port. The first result is valid in the cycle after its input transfer.
// Configuration writes are always accepted and take effect from the next byte.
module form_query_string_decoder_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qsd_cfg_if.sink    cfg_i,
  qsd_in_if.sink     in_i,
  qsd_out_if.source  out_o
);

  // ---------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------
  logic                              mode_q;
  qsd_pkg::phase_e                   phase_q, phase_d;
  logic [qsd_pkg::CHAR_W-1:0]        held_q, held_d;
  logic                              key_q, key_d;
  logic                              seen_q, seen_d;

  qsd_pkg::result_t                  grp_q [qsd_pkg::MAX_RES];
  qsd_pkg::result_t                  grp_d [qsd_pkg::MAX_RES];
  logic [qsd_pkg::RES_CNT_W-1:0]     cnt_q, cnt_d;
  logic [qsd_pkg::RES_IDX_W-1:0]     rd_q;
  logic [qsd_pkg::RES_CNT_W-1:0]     last_idx;
  logic                              at_last;
  logic                              in_fire, out_fire;

  // hex digit check and value
  function automatic logic is_hex(input logic [qsd_pkg::CHAR_W-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [qsd_pkg::CHAR_W-1:0] c);
    logic [qsd_pkg::CHAR_W-1:0] v;
    if (c >= "0" && c <= "9") begin
      v = c - 8'h30;
    end else if (c >= "a" && c <= "f") begin
      v = c - 8'h57;
    end else if (c >= "A" && c <= "F") begin
      v = c - 8'h37;
    end else begin
      v = '0;
    end
    return v[3:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.query_mode;
    end
  end

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  assign last_idx   = cnt_q - qsd_pkg::RES_CNT_W'(1);
  assign at_last    = ({1'b0, rd_q} == last_idx);
  assign out_o.valid = (cnt_q != '0);
  assign out_fire   = out_o.valid && out_o.ready;
  // free when empty, or when the last buffered result leaves this cycle
  assign in_i.ready = (cnt_q == '0) || (out_fire && at_last);
  assign in_fire    = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------
  // Decode step: results and next state for the offered input
  // ---------------------------------------------------------------------
  always_comb begin
    logic [qsd_pkg::CHAR_W-1:0] c;
    logic                       qm;
    logic                       do_plain;
    c        = in_i.char_in;
    qm       = mode_q;
    do_plain = 1'b0;
    phase_d  = phase_q;
    held_d   = held_q;
    key_d    = key_q;
    seen_d   = seen_q;
    cnt_d    = '0;
    for (int i = 0; i < qsd_pkg::MAX_RES; i++) begin
      grp_d[i] = '{kind: qsd_pkg::KIND_BYTE, data: '0};
    end

    if (in_i.char_valid) begin
      seen_d = 1'b1;
      if ((qm && c == qsd_pkg::CH_AMP) || (qm && c == qsd_pkg::CH_EQ && !key_d)) begin
        // delimiter: flush pending escape, then the mark
        if (phase_d != qsd_pkg::PH_NONE) begin
          grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_BYTE, qsd_pkg::CH_PCT};
          cnt_d = cnt_d + qsd_pkg::RES_CNT_W'(1);
        end
        if (phase_d == qsd_pkg::PH_DIGIT) begin
          grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_BYTE, held_d};
          cnt_d = cnt_d + qsd_pkg::RES_CNT_W'(1);
        end
        phase_d = qsd_pkg::PH_NONE;
        held_d  = '0;
        if (c == qsd_pkg::CH_AMP) begin
          grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_PAIR_END, '0};
          key_d = 1'b0;
        end else begin
          grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_KEY_END, '0};
          key_d = 1'b1;
        end
        cnt_d = cnt_d + qsd_pkg::RES_CNT_W'(1);
      end else begin
        do_plain = 1'b1;
        if (phase_d == qsd_pkg::PH_PCT && is_hex(c)) begin
          held_d   = c;
          phase_d  = qsd_pkg::PH_DIGIT;
          do_plain = 1'b0;
        end else if (phase_d == qsd_pkg::PH_DIGIT && is_hex(c)) begin
          grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] =
            '{qsd_pkg::KIND_BYTE, {hex_val(held_d), hex_val(c)}};
          cnt_d    = cnt_d + qsd_pkg::RES_CNT_W'(1);
          phase_d  = qsd_pkg::PH_NONE;
          held_d   = '0;
          do_plain = 1'b0;
        end else begin
          // bad escape: percent and held digit go out literally
          if (phase_d != qsd_pkg::PH_NONE) begin
            grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_BYTE, qsd_pkg::CH_PCT};
            cnt_d = cnt_d + qsd_pkg::RES_CNT_W'(1);
          end
          if (phase_d == qsd_pkg::PH_DIGIT) begin
            grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_BYTE, held_d};
            cnt_d = cnt_d + qsd_pkg::RES_CNT_W'(1);
          end
          phase_d = qsd_pkg::PH_NONE;
          held_d  = '0;
        end
        // ordinary byte handling
        if (do_plain) begin
          if (qm && c == qsd_pkg::CH_PLUS) begin
            grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_BYTE, qsd_pkg::CH_SPACE};
            cnt_d = cnt_d + qsd_pkg::RES_CNT_W'(1);
          end else if (c == qsd_pkg::CH_PCT) begin
            phase_d = qsd_pkg::PH_PCT;
          end else begin
            grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_BYTE, c};
            cnt_d = cnt_d + qsd_pkg::RES_CNT_W'(1);
          end
        end
      end
    end

    // string end: flush, closing mark unless an empty query-mode string, clear state
    if (in_i.string_end) begin
      if (phase_d != qsd_pkg::PH_NONE) begin
        grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_BYTE, qsd_pkg::CH_PCT};
        cnt_d = cnt_d + qsd_pkg::RES_CNT_W'(1);
      end
      if (phase_d == qsd_pkg::PH_DIGIT) begin
        grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_BYTE, held_d};
        cnt_d = cnt_d + qsd_pkg::RES_CNT_W'(1);
      end
      if (!qm || seen_d) begin
        grp_d[cnt_d[qsd_pkg::RES_IDX_W-1:0]] = '{qsd_pkg::KIND_PAIR_END, '0};
        cnt_d = cnt_d + qsd_pkg::RES_CNT_W'(1);
      end
      phase_d = qsd_pkg::PH_NONE;
      held_d  = '0;
      key_d   = 1'b0;
      seen_d  = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Decoder state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= qsd_pkg::PH_NONE;
      held_q  <= '0;
      key_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      key_q   <= key_d;
      seen_q  <= seen_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result buffer: count and read pointer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (in_fire) begin
      cnt_q <= cnt_d;
      rd_q  <= '0;
    end else if (out_fire) begin
      if (at_last) begin
        cnt_q <= '0;
        rd_q  <= '0;
      end else begin
        rd_q <= rd_q + qsd_pkg::RES_IDX_W'(1);
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      grp_q <= grp_d;
    end
  end

  assign out_o.item_kind = grp_q[rd_q].kind;
  assign out_o.byte_out  = grp_q[rd_q].data;
  assign out_o.run_last  = at_last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= qsd_pkg::RES_CNT_W'(qsd_pkg::MAX_RES))
    else $error("result count exceeds buffer depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cnt_q != '0) |-> (out_fire && out_o.run_last))
    else $error("result buffer reloaded before last result left");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.string_end) |=>
      (phase_q == qsd_pkg::PH_NONE && !key_q && !seen_q && held_q == '0))
    else $error("state not cleared after string end");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.item_kind != 2'd3))
    else $error("illegal result kind");

  a_marks_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.item_kind != qsd_pkg::KIND_BYTE) |-> (out_o.byte_out == '0))
    else $error("mark result carries non-zero byte");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for form_query_string_decoder_top: directed and random
// query strings, with results checked against an in-bench decode model.
// Depends on qsd_pkg, the channel interfaces in qsd_if.sv and the top-level RTL.
module testbench;

  typedef struct packed {
    qsd_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
  } decoded_t;

  logic clk;
  logic rst_n;

  qsd_cfg_if cfg_ch ();
  qsd_in_if  in_ch ();
  qsd_out_if out_ch ();

  form_query_string_decoder_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Decode model state, mirrors the block after reset
  logic            mode_q      = 1'b1;
  qsd_pkg::phase_e esc_phase   = qsd_pkg::PH_NONE;
  logic [7:0]      held_char   = 8'h00;
  logic            key_closed  = 1'b0;
  logic            str_started = 1'b0;

  decoded_t   step_res[$];
  decoded_t   expected_q[$];
  logic [7:0] raw_text[$];

  int error_count  = 0;
  int items_sent   = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  bit hold_req     = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #1600000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void emit(input qsd_pkg::kind_e k, input logic [7:0] d);
    decoded_t r;
    r.kind = k;
    r.data = (k == qsd_pkg::KIND_BYTE) ? d : 8'h00;
    r.last = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  // Pending escape goes out as a literal percent, plus the held digit
  function automatic void flush_escape();
    if (esc_phase == qsd_pkg::PH_PCT) begin
      emit(qsd_pkg::KIND_BYTE, qsd_pkg::CH_PCT);
    end else if (esc_phase == qsd_pkg::PH_DIGIT) begin
      emit(qsd_pkg::KIND_BYTE, qsd_pkg::CH_PCT);
      emit(qsd_pkg::KIND_BYTE, held_char);
    end
    esc_phase = qsd_pkg::PH_NONE;
    held_char = 8'h00;
  endfunction

  function automatic void ordinary_char(input logic [7:0] c);
    if (mode_q && c == qsd_pkg::CH_PLUS) emit(qsd_pkg::KIND_BYTE, qsd_pkg::CH_SPACE);
    else if (c == qsd_pkg::CH_PCT)       esc_phase = qsd_pkg::PH_PCT;
    else                                 emit(qsd_pkg::KIND_BYTE, c);
  endfunction

  function automatic void take_char(input logic [7:0] c);
    int lo;
    if (mode_q && c == qsd_pkg::CH_AMP) begin
      flush_escape();
      emit(qsd_pkg::KIND_PAIR_END, 8'h00);
      key_closed = 1'b0;
      return;
    end
    if (mode_q && c == qsd_pkg::CH_EQ && !key_closed) begin
      flush_escape();
      emit(qsd_pkg::KIND_KEY_END, 8'h00);
      key_closed = 1'b1;
      return;
    end
    if (esc_phase == qsd_pkg::PH_PCT) begin
      if (hex_nibble(c) >= 0) begin
        held_char = c;
        esc_phase = qsd_pkg::PH_DIGIT;
        return;
      end
      flush_escape();
    end else if (esc_phase == qsd_pkg::PH_DIGIT) begin
      lo = hex_nibble(c);
      if (lo >= 0) begin
        emit(qsd_pkg::KIND_BYTE, 8'((hex_nibble(held_char) << 4) | lo));
        esc_phase = qsd_pkg::PH_NONE;
        held_char = 8'h00;
        return;
      end
      flush_escape();
    end
    ordinary_char(c);
  endfunction

  // Works out the results of one accepted item and queues them
  function automatic void predict_item(input logic [7:0] ch, input logic has_char,
                                       input logic ends);
    decoded_t r;
    step_res.delete();
    if (has_char) begin
      str_started = 1'b1;
      take_char(ch);
    end
    if (ends) begin
      flush_escape();
      if (!mode_q || str_started) emit(qsd_pkg::KIND_PAIR_END, 8'h00);
      key_closed  = 1'b0;
      str_started = 1'b0;
    end
    for (int i = 0; i < step_res.size(); i++) begin
      r = step_res[i];
      r.last = (i == step_res.size() - 1);
      expected_q.insert(expected_q.size(), r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and checking
  // ---------------------------------------------------------------------------

  initial begin : result_ready
    int hold_cnt;
    hold_cnt = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 60;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    decoded_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0b", $time,
                 out_ch.item_kind, out_ch.byte_out, out_ch.run_last);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.item_kind !== want.kind || out_ch.byte_out !== want.data ||
            out_ch.run_last !== want.last) begin
          error_count++;
          $display("%0t: mismatch expected kind=%0d byte=%02h last=%0b, %s%0d %s%02h %s%0b",
                   $time, want.kind, want.data, want.last, "actual kind=",
                   out_ch.item_kind, "byte=", out_ch.byte_out, "last=", out_ch.run_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic [7:0] ch, input logic has_char, input logic ends);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_in    <= ch;
    in_ch.char_valid <= has_char;
    in_ch.string_end <= ends;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(ch, has_char, ends);
    if (has_char || ends) items_sent++;
  endtask

  task automatic send_str(input string s, input bit end_last);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b1, end_last && (i == s.len() - 1));
  endtask

  // Stop offering and let every outstanding result (and in-flight item) settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.query_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    mode_q = m;
    @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'h30 + 8'(r);
    if (r < 16) return 8'h61 + 8'(r - 10);
    return 8'h41 + 8'(r - 16);
  endfunction

  function automatic void add_raw(input logic [7:0] c);
    raw_text.insert(raw_text.size(), c);
  endfunction

  // Mostly well-formed pairs and escapes, some broken escapes and raw noise
  task automatic build_text(input int tokens);
    bit noise;
    noise = ($urandom_range(0, 9) == 0);
    raw_text.delete();
    for (int i = 0; i < tokens; i++) begin
      if (noise) begin
        add_raw(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 11))
          0, 1, 2: add_raw(8'h61 + 8'($urandom_range(0, 25)));
          3: begin
            add_raw(qsd_pkg::CH_PCT);
            add_raw(hex_char());
            add_raw(hex_char());
          end
          4: begin
            add_raw(qsd_pkg::CH_PCT);
            if ($urandom_range(0, 1)) add_raw(hex_char());
            add_raw(8'($urandom_range(0, 255)));
          end
          5:  add_raw(qsd_pkg::CH_AMP);
          6:  add_raw(qsd_pkg::CH_EQ);
          7:  add_raw(qsd_pkg::CH_PLUS);
          8:  add_raw(8'($urandom_range(0, 255)));
          9:  add_raw(8'h30 + 8'($urandom_range(0, 9)));
          10: add_raw(qsd_pkg::CH_PCT);
          default: add_raw(hex_char());
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Query mode: delimiters, plus, escapes good and bad, flushes, empty string
  task automatic test_query_directed();
    write_mode(1'b1);
    send_item(8'h00, 1'b0, 1'b1);      // empty string: nothing out
    send_item(8'h00, 1'b0, 1'b0);      // bare item: no effect
    send_str("k+==", 1'b0);            // second equals is a plain byte
    send_str("%41%fF%z%ag", 1'b0);
    send_str("%4&", 1'b1);             // flush, pair end and string end together
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_str("%", 1'b1);               // cut-off escape at string end
    send_str("%=%9", 1'b0);
    send_item(8'h00, 1'b0, 1'b1);      // bare end mark flushes held digit
  endtask

  // Plain mode: only escapes decoded, empty string still gives an end mark
  task automatic test_plain_directed();
    write_mode(1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_str("a+=&%41%4", 1'b1);
    send_str("%g+", 1'b1);
  endtask

  // Mode written mid-string: pending escape kept across the change
  task automatic test_mode_switch_mid_string();
    send_str("x%4", 1'b0);
    write_mode(1'b1);
    send_str("=+", 1'b0);
    write_mode(1'b0);
    send_str("+&", 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // Long receiver hold-off while input keeps coming, so the buffer fills
  task automatic test_output_hold();
    write_mode(1'b1);
    hold_req = 1'b1;
    send_str("a%41&b=c+d%2B%zz&e=%4%", 1'b1);
    drain();
  endtask

  task automatic test_random(input int n, input int s_pct, input int r_pct);
    int  start;
    bit  end_on_char;
    send_gap_pct = s_pct;
    recv_gap_pct = r_pct;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 4) == 0) write_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      build_text($urandom_range(0, 6));
      end_on_char = ($urandom_range(0, 9) < 7) && (raw_text.size() != 0);
      for (int i = 0; i < raw_text.size(); i++)
        send_item(raw_text[i], 1'b1, end_on_char && (i == raw_text.size() - 1));
      if (!end_on_char) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.char_in     = 8'h00;
    in_ch.char_valid  = 1'b0;
    in_ch.string_end  = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.query_mode = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 13;
    recv_gap_pct = 70;
    test_query_directed();
    test_plain_directed();
    test_mode_switch_mid_string();
    test_random(13, 13, 70);
    test_random(13, 70, 13);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_output_hold();
    test_random(12, 0, 0);

    drain();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* form_query_string_decoder_top.f */
rtl/qsd_pkg.sv
rtl/qsd_if.sv
rtl/form_query_string_decoder_top.sv
sim/testbench.sv
